// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the monitor RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds on every clock edge out of reset.
`define HBM_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define HBM_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define HBM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/hbm_pkg.sv =====
// Shared types, codes and sizing constants of the heartbeat health monitor.
// No dependencies; every other RTL file but assert_macros.svh imports this package.
`default_nettype none

package hbm_pkg;

    // Sizing
    localparam int WORKERS    = 16;
    localparam int TIME_WIDTH = 32;
    localparam int SLOTS      = WORKERS + 2;
    localparam int SA_W       = $clog2(SLOTS);
    localparam int LA_W       = (WORKERS > 1) ? $clog2(WORKERS) : 1;
    localparam int WC_W       = $clog2(WORKERS + 1);
    localparam int CMP_W      = (TIME_WIDTH > 31) ? TIME_WIDTH : 31;

    // Field widths
    localparam int FUNC_W  = 3;
    localparam int NODE_W  = 5;
    localparam int STATE_W = 3;
    localparam int CPU_W   = 10;
    localparam int RAM_W   = 22;
    localparam int KIND_W  = 3;
    localparam int ACT_W   = 3;

    // Load fixed point: 1.0 is LOAD_SCALE
    localparam int LOAD_SCALE = 1024;
    localparam int MEM_PW     = 34;

    // Node ids of the two special slots
    localparam logic [NODE_W-1:0] MASTER_ID    = 5'd16;
    localparam logic [NODE_W-1:0] SECONDARY_ID = 5'd17;
    localparam logic [SA_W-1:0]   MASTER_ADDR    = SA_W'(WORKERS);
    localparam logic [SA_W-1:0]   SECONDARY_ADDR = SA_W'(WORKERS + 1);

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CPU_TH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MEM_TH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WORKERS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROLE    = 3'd4;

    // Input function codes
    localparam logic [FUNC_W-1:0] FN_HEARTBEAT = 3'd0;
    localparam logic [FUNC_W-1:0] FN_REPORT    = 3'd1;
    localparam logic [FUNC_W-1:0] FN_SET_STATE = 3'd2;
    localparam logic [FUNC_W-1:0] FN_TICK      = 3'd3;
    localparam logic [FUNC_W-1:0] FN_CHECK     = 3'd4;

    // Node states
    localparam logic [STATE_W-1:0] NS_DISC   = 3'd0;
    localparam logic [STATE_W-1:0] NS_ACTIVE = 3'd1;
    localparam logic [STATE_W-1:0] NS_OVER   = 3'd2;
    localparam logic [STATE_W-1:0] NS_FAILED = 3'd3;
    localparam logic [STATE_W-1:0] NS_MAINT  = 3'd4;

    // Event kinds
    localparam logic [KIND_W-1:0] EV_NONE     = 3'd0;
    localparam logic [KIND_W-1:0] EV_BEAT     = 3'd1;
    localparam logic [KIND_W-1:0] EV_CPU      = 3'd2;
    localparam logic [KIND_W-1:0] EV_MEM      = 3'd3;
    localparam logic [KIND_W-1:0] EV_MASTER   = 3'd4;
    localparam logic [KIND_W-1:0] EV_SECONDARY = 3'd5;

    // Recovery actions
    localparam logic [ACT_W-1:0] ACT_NONE     = 3'd0;
    localparam logic [ACT_W-1:0] ACT_MIGRATE  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_THROTTLE = 3'd2;
    localparam logic [ACT_W-1:0] ACT_PROMOTE  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_ELECT    = 3'd4;

    // Roles
    localparam logic [1:0] ROLE_MASTER    = 2'd0;
    localparam logic [1:0] ROLE_WORKER    = 2'd1;
    localparam logic [1:0] ROLE_SECONDARY = 2'd2;

    // Control sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RD,
        ST_CK_EV,
        ST_CK_END
    } fsm_t;

    // Channel payloads
    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [NODE_W-1:0]  node_id;
        logic [STATE_W-1:0] req_state;
        logic [CPU_W-1:0]   cpu_frac;
        logic [RAM_W-1:0]   ram_free_mb;
        logic [RAM_W-1:0]   ram_size_mb;
    } cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0]  event_kind;
        logic [NODE_W-1:0]  event_node;
        logic [ACT_W-1:0]   action;
        logic [STATE_W-1:0] prior_state;
        logic [STATE_W-1:0] now_state;
        logic               last;
    } evt_t;

    // Memory entries
    typedef struct packed {
        logic [STATE_W-1:0]    state;
        logic [TIME_WIDTH-1:0] beat;
    } st_entry_t;

    typedef struct packed {
        logic [CPU_W-1:0] cpu;
        logic [RAM_W-1:0] ram_free;
        logic [RAM_W-1:0] ram_total;
    } ld_entry_t;

    // Memory access request bundle
    typedef struct packed {
        logic            st_re;
        logic [SA_W-1:0] st_ra;
        logic            st_we;
        logic [SA_W-1:0] st_wa;
        st_entry_t       st_wd;
        logic            ld_re;
        logic [LA_W-1:0] ld_ra;
        logic            ld_we;
        logic [LA_W-1:0] ld_wa;
        ld_entry_t       ld_wd;
    } mem_req_t;

    // Slot lookup result
    typedef struct packed {
        logic            ok;
        logic [SA_W-1:0] addr;
    } slot_t;

    // Map a node id onto a slot address
    function automatic slot_t slot_of(input logic [NODE_W-1:0] id);
        slot_t s;
        s.ok   = 1'b0;
        s.addr = '0;
        if ((32'(id) < WORKERS) && (id < MASTER_ID))
        begin
            s.ok   = 1'b1;
            s.addr = SA_W'(id);
        end
        else if (id == MASTER_ID)
        begin
            s.ok   = 1'b1;
            s.addr = MASTER_ADDR;
        end
        else if (id == SECONDARY_ID)
        begin
            s.ok   = 1'b1;
            s.addr = SECONDARY_ADDR;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/hbm_cmd_if.sv =====
// Input channel of the monitor: valid, ready and one command beat.
// Depends on hbm_pkg for the payload type.
`default_nettype none

interface hbm_cmd_if;
    import hbm_pkg::*;

    logic valid;
    logic ready;
    cmd_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/hbm_evt_if.sv =====
// Output channel of the monitor: valid, ready and one event beat.
// Depends on hbm_pkg for the payload type.
`default_nettype none

interface hbm_evt_if;
    import hbm_pkg::*;

    logic valid;
    logic ready;
    evt_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/hbm_node_mem.sv =====
// Node state/stamp memory and worker load memory, one read and one write port each.
// Valid bits give reset contents; depends on hbm_pkg.
`default_nettype none

module hbm_node_mem (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  hbm_pkg::mem_req_t        req,
    output hbm_pkg::st_entry_t       st_rdata,
    output hbm_pkg::ld_entry_t       ld_rdata
);
    import hbm_pkg::*;

    st_entry_t        st_mem [SLOTS];
    ld_entry_t        ld_mem [WORKERS];
    logic [SLOTS-1:0]   st_vld_reg;
    logic [WORKERS-1:0] ld_vld_reg;
    st_entry_t        st_q_reg;
    ld_entry_t        ld_q_reg;
    logic             st_qv_reg;
    logic             ld_qv_reg;

    // Write the arrays
    always_ff @(posedge clk)
    begin
        if (req.st_we)
        begin
            st_mem[req.st_wa] <= req.st_wd;
        end
        if (req.ld_we)
        begin
            ld_mem[req.ld_wa] <= req.ld_wd;
        end
    end

    // Register the read data
    always_ff @(posedge clk)
    begin
        if (req.st_re)
        begin
            st_q_reg <= st_mem[req.st_ra];
        end
        if (req.ld_re)
        begin
            ld_q_reg <= ld_mem[req.ld_ra];
        end
    end

    // Track written entries and the valid flag of each read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_vld_reg <= '0;
            ld_vld_reg <= '0;
            st_qv_reg  <= 1'b0;
            ld_qv_reg  <= 1'b0;
        end
        else
        begin
            if (req.st_re)
            begin
                st_qv_reg <= st_vld_reg[req.st_ra];
            end
            if (req.ld_re)
            begin
                ld_qv_reg <= ld_vld_reg[req.ld_ra];
            end
            if (req.st_we)
            begin
                st_vld_reg[req.st_wa] <= 1'b1;
            end
            if (req.ld_we)
            begin
                ld_vld_reg[req.ld_wa] <= 1'b1;
            end
        end
    end

    // Never-written entries read as zero: disconnected, stamp and loads zero
    assign st_rdata = st_qv_reg ? st_q_reg : '0;
    assign ld_rdata = ld_qv_reg ? ld_q_reg : '0;

endmodule

`default_nettype wire

// ===== rtl/core/heartbeat_node_health_monitor.sv =====
// Top level of the heartbeat node health monitor: control sequencer, time counter,
// configuration registers and output register. Depends on hbm_pkg, the two channel
// interfaces, hbm_node_mem and assert_macros.svh.
//
// The monitor takes one command beat at a time. A heartbeat, load report, state
// write, tick or unknown code goes from ST_IDLE to ST_RD: the accept cycle issues
// the read of the node slot, and ST_RD does the read-modify-write and loads the
// result into the output register once that register is free, after which the
// next beat is accepted. A check reads the W worker slots in use (capped at 16),
// then the master or secondary slot when the role watches it: the state memory
// has one read port and the walk visits one slot per cycle while no finding
// waits for the output register, so a full check gives up to 18 event beats.
// Configuration writes take effect at once and must be made while no command is
// in flight. Reset state needs no clearing pass: every memory entry carries a
// valid bit and reads as zero until written.
`default_nettype none

module heartbeat_node_health_monitor (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [hbm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [hbm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    hbm_cmd_if.sink                              cmd,
    hbm_evt_if.source                            evt
);
    import hbm_pkg::*;

`include "assert_macros.svh"

    // Configuration
    logic [30:0]      timeout_reg;
    logic [CPU_W-1:0] cpu_th_reg;
    logic [CPU_W-1:0] mem_th_reg;
    logic [4:0]       workers_reg;
    logic [1:0]       role_reg;

    // Control and datapath registers
    fsm_t                  state_reg, state_next;
    logic [SA_W-1:0]       walk_reg, walk_next;
    logic [TIME_WIDTH-1:0] time_reg, time_next;
    logic                  out_valid_reg, out_valid_next;
    evt_t                  out_data_reg, out_data_next;
    cmd_t                  op_reg;

    mem_req_t  mem_req;
    st_entry_t cur;
    ld_entry_t load;

    logic            cmd_accept;
    logic            out_free;
    slot_t           in_slot;
    slot_t           op_slot;
    logic [WC_W-1:0] wc;
    logic            tail_en;
    logic [SA_W-1:0] tail_addr;
    logic            op_is_w;
    logic            op_in_wc;
    logic [STATE_W-1:0] hb_state;

    // Slot evaluation
    logic [TIME_WIDTH-1:0] age;
    logic                  alive;
    logic                  cpu_over;
    logic                  mem_over;
    logic [MEM_PW-1:0]     mem_lhs;
    logic [MEM_PW-1:0]     mem_rhs;
    logic [RAM_W:0]        tot_plus;
    logic [CPU_W:0]        headroom;
    logic                  walk_is_w;
    logic                  walk_more;
    logic                  finding;
    logic [STATE_W-1:0]    f_state;
    logic [KIND_W-1:0]     f_kind;
    logic [ACT_W-1:0]      f_act;
    logic [NODE_W-1:0]     f_node;

    // Checked conditions
    logic                  rw_same_slot;
    logic                  fault_beat;

    hbm_node_mem u_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (mem_req),
        .st_rdata (cur),
        .ld_rdata (load)
    );

    // Take configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= 31'd3000;
            cpu_th_reg  <= 10'd922;
            mem_th_reg  <= 10'd922;
            workers_reg <= 5'd0;
            role_reg    <= ROLE_MASTER;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TIMEOUT: timeout_reg <= cfg_wdata[30:0];
                CFG_CPU_TH:  cpu_th_reg  <= cfg_wdata[CPU_W-1:0];
                CFG_MEM_TH:  mem_th_reg  <= cfg_wdata[CPU_W-1:0];
                CFG_WORKERS: workers_reg <= cfg_wdata[4:0];
                CFG_ROLE:    role_reg    <= cfg_wdata[1:0];
                default:     ;
            endcase
        end
    end

    // Derived control values
    assign wc = (32'(workers_reg) > WORKERS) ? WC_W'(WORKERS) : WC_W'(workers_reg);
    assign tail_en   = (role_reg == ROLE_SECONDARY) || (role_reg == ROLE_MASTER);
    assign tail_addr = (role_reg == ROLE_SECONDARY) ? MASTER_ADDR : SECONDARY_ADDR;

    assign cmd_accept = cmd.valid && cmd.ready;
    assign out_free   = !out_valid_reg || evt.ready;
    assign in_slot    = slot_of(cmd.payload.node_id);
    assign op_slot    = slot_of(op_reg.node_id);
    assign op_is_w    = 32'(op_slot.addr) < WORKERS;
    assign op_in_wc   = 32'(op_slot.addr) < 32'(wc);
    assign hb_state   = ((cur.state == NS_FAILED) || (cur.state == NS_DISC)) ?
                        NS_ACTIVE : cur.state;

    // Age and load tests on the slot just read
    assign age      = time_reg - cur.beat;
    assign alive    = (cur.state == NS_MAINT) || (CMP_W'(age) < CMP_W'(timeout_reg));
    assign cpu_over = load.cpu > cpu_th_reg;
    assign tot_plus = {1'b0, load.ram_total} + (RAM_W + 1)'(1);
    assign headroom = (CPU_W + 1)'(LOAD_SCALE) - {1'b0, mem_th_reg};
    assign mem_lhs  = MEM_PW'({load.ram_free, 10'd0});
    assign mem_rhs  = MEM_PW'(tot_plus) * MEM_PW'(headroom);
    assign mem_over = mem_lhs < mem_rhs;

    assign walk_is_w = 32'(walk_reg) < WORKERS;
    assign walk_more = walk_is_w && ((32'(walk_reg) + 1) < 32'(wc));

    // Decide the finding for the slot under the walk
    always_comb
    begin
        finding = 1'b0;
        f_state = cur.state;
        f_kind  = EV_NONE;
        f_act   = ACT_NONE;
        f_node  = NODE_W'(walk_reg);
        if (walk_is_w)
        begin
            if (cur.state == NS_ACTIVE)
            begin
                if (!alive)
                begin
                    finding = 1'b1;
                    f_state = NS_FAILED;
                    f_kind  = EV_BEAT;
                    f_act   = ACT_MIGRATE;
                end
                else if (cpu_over || mem_over)
                begin
                    finding = 1'b1;
                    f_state = NS_OVER;
                    f_kind  = cpu_over ? EV_CPU : EV_MEM;
                    f_act   = ACT_THROTTLE;
                end
            end
        end
        else if (walk_reg == MASTER_ADDR)
        begin
            f_node = MASTER_ID;
            if (!alive && (cur.state != NS_FAILED) && (cur.state != NS_DISC))
            begin
                finding = 1'b1;
                f_state = NS_FAILED;
                f_kind  = EV_MASTER;
                f_act   = ACT_PROMOTE;
            end
        end
        else
        begin
            f_node = SECONDARY_ID;
            if (!alive && (cur.state == NS_ACTIVE))
            begin
                finding = 1'b1;
                f_state = NS_FAILED;
                f_kind  = EV_SECONDARY;
                f_act   = ACT_ELECT;
            end
        end
    end

    // Sequence commands through the memories
    always_comb
    begin
        state_next     = state_reg;
        walk_next      = walk_reg;
        time_next      = time_reg;
        out_valid_next = out_valid_reg && !evt.ready;
        out_data_next  = out_data_reg;
        mem_req        = '0;
        cmd.ready      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                cmd.ready = 1'b1;
                if (cmd.valid)
                begin
                    if (cmd.payload.func == FN_CHECK)
                    begin
                        if (wc != '0)
                        begin
                            mem_req.st_re = 1'b1;
                            mem_req.st_ra = '0;
                            mem_req.ld_re = 1'b1;
                            mem_req.ld_ra = '0;
                            walk_next     = '0;
                            state_next    = ST_CK_EV;
                        end
                        else if (tail_en)
                        begin
                            mem_req.st_re = 1'b1;
                            mem_req.st_ra = tail_addr;
                            walk_next     = tail_addr;
                            state_next    = ST_CK_EV;
                        end
                        else
                        begin
                            state_next = ST_CK_END;
                        end
                    end
                    else
                    begin
                        mem_req.st_re = in_slot.ok;
                        mem_req.st_ra = in_slot.addr;
                        state_next    = ST_RD;
                    end
                end
            end

            ST_RD:
            begin
                if (out_free)
                begin
                    state_next               = ST_IDLE;
                    out_valid_next           = 1'b1;
                    out_data_next            = '0;
                    out_data_next.last       = 1'b1;
                    out_data_next.event_node = op_reg.node_id;
                    case (op_reg.func)
                        FN_TICK:
                        begin
                            time_next                = time_reg + TIME_WIDTH'(1);
                            out_data_next.event_node = '0;
                        end
                        FN_HEARTBEAT:
                        begin
                            if (op_slot.ok)
                            begin
                                out_data_next.prior_state = cur.state;
                                out_data_next.now_state   = cur.state;
                                if (!op_is_w)
                                begin
                                    mem_req.st_we       = 1'b1;
                                    mem_req.st_wa       = op_slot.addr;
                                    mem_req.st_wd.state = cur.state;
                                    mem_req.st_wd.beat  = time_reg;
                                end
                                else if (op_in_wc)
                                begin
                                    mem_req.st_we           = 1'b1;
                                    mem_req.st_wa           = op_slot.addr;
                                    mem_req.st_wd.state     = hb_state;
                                    mem_req.st_wd.beat      = time_reg;
                                    out_data_next.now_state = hb_state;
                                end
                            end
                        end
                        FN_REPORT:
                        begin
                            if (op_slot.ok)
                            begin
                                out_data_next.prior_state = cur.state;
                                out_data_next.now_state   = cur.state;
                                if (op_is_w)
                                begin
                                    mem_req.ld_we           = 1'b1;
                                    mem_req.ld_wa           = LA_W'(op_slot.addr);
                                    mem_req.ld_wd.cpu       = op_reg.cpu_frac;
                                    mem_req.ld_wd.ram_free  = op_reg.ram_free_mb;
                                    mem_req.ld_wd.ram_total = op_reg.ram_size_mb;
                                end
                            end
                        end
                        FN_SET_STATE:
                        begin
                            if (op_slot.ok)
                            begin
                                out_data_next.prior_state = cur.state;
                                out_data_next.now_state   = cur.state;
                                if (op_reg.req_state <= NS_MAINT)
                                begin
                                    mem_req.st_we           = 1'b1;
                                    mem_req.st_wa           = op_slot.addr;
                                    mem_req.st_wd.state     = op_reg.req_state;
                                    mem_req.st_wd.beat      = cur.beat;
                                    out_data_next.now_state = op_reg.req_state;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end

            ST_CK_EV:
            begin
                // Advance unless a finding waits for the output register
                if (!finding || out_free)
                begin
                    if (finding)
                    begin
                        mem_req.st_we       = 1'b1;
                        mem_req.st_wa       = walk_reg;
                        mem_req.st_wd.state = f_state;
                        mem_req.st_wd.beat  = cur.beat;
                        out_valid_next      = 1'b1;
                        out_data_next.event_kind  = f_kind;
                        out_data_next.event_node  = f_node;
                        out_data_next.action      = f_act;
                        out_data_next.prior_state = cur.state;
                        out_data_next.now_state   = f_state;
                        out_data_next.last        = 1'b0;
                    end
                    // Read the next slot; it never equals the one written back
                    if (walk_more)
                    begin
                        mem_req.st_re = 1'b1;
                        mem_req.st_ra = walk_reg + SA_W'(1);
                        mem_req.ld_re = 1'b1;
                        mem_req.ld_ra = LA_W'(walk_reg + SA_W'(1));
                        walk_next     = walk_reg + SA_W'(1);
                    end
                    else if (walk_is_w && tail_en)
                    begin
                        mem_req.st_re = 1'b1;
                        mem_req.st_ra = tail_addr;
                        walk_next     = tail_addr;
                    end
                    else
                    begin
                        state_next = ST_CK_END;
                    end
                end
            end

            ST_CK_END:
            begin
                // Close the check with the marker beat
                if (out_free)
                begin
                    out_valid_next     = 1'b1;
                    out_data_next      = '0;
                    out_data_next.last = 1'b1;
                    state_next         = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            walk_reg      <= '0;
            time_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            walk_reg      <= walk_next;
            time_reg      <= time_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold payloads
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (cmd_accept)
        begin
            op_reg <= cmd.payload;
        end
    end

    assign evt.valid   = out_valid_reg;
    assign evt.payload = out_data_reg;

    assign rw_same_slot = mem_req.st_we && mem_req.st_re && (mem_req.st_wa == mem_req.st_ra);
    assign fault_beat   = evt.valid && (evt.payload.event_kind != EV_NONE);

    `HBM_ASSERT_IMPLIES(a_idle_no_write, state_reg == ST_IDLE, !mem_req.st_we, "write while idle")
    `HBM_ASSERT_ALWAYS(a_rmw_split, !rw_same_slot, "read and write hit one slot")
    `HBM_ASSERT_IMPLIES(a_walk_range, state_reg == ST_CK_EV, 32'(walk_reg) < SLOTS, "walk too far")
    `HBM_ASSERT_NEXT(a_accept_busy, cmd_accept, state_reg != ST_IDLE, "accept left sequencer idle")
    `HBM_ASSERT_IMPLIES(a_finding_not_last, fault_beat, !evt.payload.last, "finding marked last")

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for heartbeat_node_health_monitor: directed and random commands,
// with results checked beat by beat against a predictor of the node state table.
// Depends on hbm_pkg, hbm_cmd_if, hbm_evt_if and the monitor RTL.
`default_nettype none

module tb;
    import hbm_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    // Codes with no name in the package
    localparam logic [FUNC_W-1:0]  FN_UNUSED    = 3'd7;
    localparam logic [STATE_W-1:0] NS_BAD       = 3'd7;
    localparam logic [NODE_W-1:0]  NODE_NONE    = 5'd31;
    localparam logic [1:0]         ROLE_UNKNOWN = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    hbm_cmd_if cmd_bus ();
    hbm_evt_if evt_bus ();

    heartbeat_node_health_monitor dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd_bus),
        .evt       (evt_bus)
    );

    // Predicted monitor state, reset values included
    logic [TIME_WIDTH-1:0] tick_count = '0;
    logic [STATE_W-1:0]    slot_state [SLOTS] = '{default: NS_DISC};
    logic [TIME_WIDTH-1:0] slot_beat [SLOTS] = '{default: '0};
    logic [CPU_W-1:0]      worker_cpu [WORKERS] = '{default: '0};
    logic [RAM_W-1:0]      worker_free [WORKERS] = '{default: '0};
    logic [RAM_W-1:0]      worker_total [WORKERS] = '{default: '0};

    logic [30:0]     timeout_limit  = 31'd3000;
    logic [CPU_W-1:0] cpu_limit     = 10'd922;
    logic [CPU_W-1:0] mem_limit     = 10'd922;
    logic [WC_W-1:0] workers_in_use = '0;
    logic [1:0]      own_role       = ROLE_MASTER;

    evt_t pending_events [$];
    int   mismatch_count = 0;
    bit   idle_on        = 1'b1;
    int   ready_holdoff  = 0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void push_event(input logic [KIND_W-1:0] kind,
                                       input logic [NODE_W-1:0] node,
                                       input logic [ACT_W-1:0] act,
                                       input logic [STATE_W-1:0] prior,
                                       input logic [STATE_W-1:0] after,
                                       input logic closing);
        evt_t e;
        e.event_kind  = kind;
        e.event_node  = node;
        e.action      = act;
        e.prior_state = prior;
        e.now_state   = after;
        e.last        = closing;
        pending_events.push_back(e);
    endfunction

    function automatic bit node_alive(input int s);
        logic [TIME_WIDTH-1:0] age;
        age = tick_count - slot_beat[s];
        return (slot_state[s] == NS_MAINT) || (age < timeout_limit);
    endfunction

    // Apply one command to the state table and queue the event beats it causes
    function automatic void predict_events(input cmd_t c);
        int                 slot;
        int                 walk;
        logic [STATE_W-1:0] prior;
        logic [STATE_W-1:0] ws;
        bit                 cpu_hot;
        bit                 mem_hot;
        longint unsigned    free_scaled;
        longint unsigned    free_floor;
        if (c.node_id < NODE_W'(WORKERS))
            slot = int'(c.node_id);
        else if (c.node_id == MASTER_ID)
            slot = WORKERS;
        else if (c.node_id == SECONDARY_ID)
            slot = WORKERS + 1;
        else
            slot = SLOTS;
        walk  = (workers_in_use > WC_W'(WORKERS)) ? WORKERS : int'(workers_in_use);
        prior = (slot < SLOTS) ? slot_state[slot] : NS_DISC;

        if (c.func == FN_TICK)
        begin
            tick_count = tick_count + 1'b1;
            push_event(EV_NONE, '0, ACT_NONE, NS_DISC, NS_DISC, 1'b1);
        end
        else if (c.func == FN_CHECK)
        begin
            // Walk the workers in use; only active ones can raise a fault
            for (int i = 0; i < walk; i++)
            begin
                ws          = slot_state[i];
                cpu_hot     = worker_cpu[i] > cpu_limit;
                free_scaled = longint'(worker_free[i]) * longint'(LOAD_SCALE);
                free_floor  = (longint'(worker_total[i]) + 64'd1)
                              * (longint'(LOAD_SCALE) - longint'(mem_limit));
                mem_hot     = free_scaled < free_floor;
                if (ws != NS_ACTIVE)
                    continue;
                if (!node_alive(i))
                begin
                    slot_state[i] = NS_FAILED;
                    push_event(EV_BEAT, NODE_W'(i), ACT_MIGRATE, ws, NS_FAILED, 1'b0);
                end
                else if (cpu_hot || mem_hot)
                begin
                    slot_state[i] = NS_OVER;
                    push_event(cpu_hot ? EV_CPU : EV_MEM, NODE_W'(i), ACT_THROTTLE,
                               ws, NS_OVER, 1'b0);
                end
            end
            // Then watch the peer that the role cares about
            if (own_role == ROLE_SECONDARY)
            begin
                ws = slot_state[WORKERS];
                if (!node_alive(WORKERS) && ws != NS_FAILED && ws != NS_DISC)
                begin
                    slot_state[WORKERS] = NS_FAILED;
                    push_event(EV_MASTER, MASTER_ID, ACT_PROMOTE, ws, NS_FAILED, 1'b0);
                end
            end
            else if (own_role == ROLE_MASTER)
            begin
                ws = slot_state[WORKERS + 1];
                if (!node_alive(WORKERS + 1) && ws == NS_ACTIVE)
                begin
                    slot_state[WORKERS + 1] = NS_FAILED;
                    push_event(EV_SECONDARY, SECONDARY_ID, ACT_ELECT, ws, NS_FAILED, 1'b0);
                end
            end
            push_event(EV_NONE, '0, ACT_NONE, NS_DISC, NS_DISC, 1'b1);
        end
        else if (slot < SLOTS && c.func <= FN_SET_STATE)
        begin
            case (c.func)
                FN_HEARTBEAT:
                begin
                    if (slot >= WORKERS)
                        slot_beat[slot] = tick_count;
                    else if (slot < walk)
                    begin
                        slot_beat[slot] = tick_count;
                        if (slot_state[slot] == NS_FAILED || slot_state[slot] == NS_DISC)
                            slot_state[slot] = NS_ACTIVE;
                    end
                end
                FN_REPORT:
                begin
                    if (slot < WORKERS)
                    begin
                        worker_cpu[slot]   = c.cpu_frac;
                        worker_free[slot]  = c.ram_free_mb;
                        worker_total[slot] = c.ram_size_mb;
                    end
                end
                FN_SET_STATE:
                begin
                    if (c.req_state <= NS_MAINT)
                        slot_state[slot] = c.req_state;
                end
                default: ;
            endcase
            push_event(EV_NONE, c.node_id, ACT_NONE, prior, slot_state[slot], 1'b1);
        end
        else
            push_event(EV_NONE, c.node_id, ACT_NONE, NS_DISC, NS_DISC, 1'b1);
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    function automatic cmd_t cmd_of(input logic [FUNC_W-1:0] f,
                                    input logic [NODE_W-1:0] node,
                                    input logic [STATE_W-1:0] st = NS_DISC,
                                    input logic [CPU_W-1:0] cpu = '0,
                                    input logic [RAM_W-1:0] free_mb = '0,
                                    input logic [RAM_W-1:0] total_mb = '0);
        cmd_t c;
        c.func        = f;
        c.node_id     = node;
        c.req_state   = st;
        c.cpu_frac    = cpu;
        c.ram_free_mb = free_mb;
        c.ram_size_mb = total_mb;
        return c;
    endfunction

    // Offer one command beat, hold it until accepted, then predict its events
    task automatic send_cmd(input cmd_t c);
        int gap;
        gap = idle_on ? $urandom_range(0, 10) : 0;
        if (gap > 0)
        begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_bus.valid   <= 1'b1;
        cmd_bus.payload <= c;
        do
            @(posedge clk);
        while (cmd_bus.ready !== 1'b1);
        predict_events(c);
    endtask

    // Drop valid and wait until every predicted event has been seen
    task automatic drain_events();
        cmd_bus.valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        case (idx)
            CFG_TIMEOUT: timeout_limit  = value[30:0];
            CFG_CPU_TH:  cpu_limit      = value[CPU_W-1:0];
            CFG_MEM_TH:  mem_limit      = value[CPU_W-1:0];
            CFG_WORKERS: workers_in_use = value[WC_W-1:0];
            CFG_ROLE:    own_role       = value[1:0];
            default: ;
        endcase
    endtask

    // Write all registers back to back; call only while the monitor is idle
    task automatic program_monitor(input logic [30:0] timeout,
                                   input logic [CPU_W-1:0] cpu_th,
                                   input logic [CPU_W-1:0] mem_th,
                                   input logic [WC_W-1:0] workers,
                                   input logic [1:0] role);
        write_reg(CFG_TIMEOUT, CFG_DATA_W'(timeout));
        write_reg(CFG_CPU_TH, CFG_DATA_W'(cpu_th));
        write_reg(CFG_MEM_TH, CFG_DATA_W'(mem_th));
        write_reg(CFG_WORKERS, CFG_DATA_W'(workers));
        write_reg(CFG_ROLE, CFG_DATA_W'(role));
        cfg_we <= 1'b0;
    endtask

    // Mostly well-formed traffic on slots in use, with some noise mixed in
    function automatic cmd_t random_cmd();
        cmd_t c;
        int   span;
        int   pick;
        span = (workers_in_use > WC_W'(WORKERS)) ? WORKERS : int'(workers_in_use);
        if (span == 0)
            span = 1;
        c.cpu_frac    = CPU_W'($urandom);
        c.ram_size_mb = RAM_W'($urandom);
        c.ram_free_mb = RAM_W'($urandom);
        c.req_state   = STATE_W'($urandom_range(0, 4));
        if ($urandom_range(0, 5) == 0)
            c.node_id = NODE_W'($urandom_range(16, 17));
        else
            c.node_id = NODE_W'($urandom_range(0, span - 1));
        pick = $urandom_range(0, 99);
        if (pick < 20)
            c.func = FN_HEARTBEAT;
        else if (pick < 35)
        begin
            c.func = FN_REPORT;
            if ($urandom_range(0, 1) == 1)
                c.ram_free_mb = RAM_W'($urandom_range(0, c.ram_size_mb));
        end
        else if (pick < 45)
            c.func = FN_SET_STATE;
        else if (pick < 70)
            c.func = FN_TICK;
        else if (pick < 85)
            c.func = FN_CHECK;
        else
        begin
            c.func      = FUNC_W'($urandom_range(0, 7));
            c.node_id   = NODE_W'($urandom_range(0, 31));
            c.req_state = STATE_W'($urandom_range(0, 7));
        end
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Event sink: check each beat, stall ready at random or on request
    // ------------------------------------------------------------------
    initial
    begin : event_sink
        evt_t got;
        evt_t want;
        int   stall;
        stall         = 0;
        evt_bus.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (evt_bus.valid === 1'b1 && evt_bus.ready === 1'b1)
            begin
                got = evt_bus.payload;
                if (pending_events.size() == 0)
                begin
                    $error("unexpected event beat: kind %0d node %0d",
                           got.event_kind, got.event_node);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_events.pop_front();
                    if (got.event_kind !== want.event_kind)
                    begin
                        $error("event_kind: expected %0d, got %0d",
                               want.event_kind, got.event_kind);
                        mismatch_count++;
                    end
                    if (got.event_node !== want.event_node)
                    begin
                        $error("event_node: expected %0d, got %0d",
                               want.event_node, got.event_node);
                        mismatch_count++;
                    end
                    if (got.action !== want.action)
                    begin
                        $error("action: expected %0d, got %0d", want.action, got.action);
                        mismatch_count++;
                    end
                    if (got.prior_state !== want.prior_state)
                    begin
                        $error("prior_state: expected %0d, got %0d",
                               want.prior_state, got.prior_state);
                        mismatch_count++;
                    end
                    if (got.now_state !== want.now_state)
                    begin
                        $error("now_state: expected %0d, got %0d",
                               want.now_state, got.now_state);
                        mismatch_count++;
                    end
                    if (got.last !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, got.last);
                        mismatch_count++;
                    end
                end
                stall = idle_on ? $urandom_range(0, 10) : 0;
            end
            if (ready_holdoff > 0)
            begin
                evt_bus.ready <= 1'b0;
                ready_holdoff--;
            end
            else if (stall > 0)
            begin
                evt_bus.ready <= 1'b0;
                stall--;
            end
            else
                evt_bus.ready <= 1'b1;
        end
    end

    // Watchdog
    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset configuration: no workers in use, master role
    task automatic test_defaults();
        send_cmd(cmd_of(FN_CHECK, '0));
        send_cmd(cmd_of(FN_HEARTBEAT, 5'd0));
        send_cmd(cmd_of(FN_HEARTBEAT, MASTER_ID));
        send_cmd(cmd_of(FN_HEARTBEAT, NODE_NONE));
        send_cmd(cmd_of(FN_UNUSED, 5'd5));
        send_cmd(cmd_of(FN_TICK, NODE_NONE));
    endtask

    // Worker faults, secondary loss, ignored writes and worker count above the slots
    task automatic test_fault_events();
        drain_events();
        program_monitor(31'd2, 10'd500, 10'd0, 5'd31, ROLE_MASTER);
        send_cmd(cmd_of(FN_SET_STATE, 5'd0, NS_ACTIVE));
        send_cmd(cmd_of(FN_REPORT, 5'd0, NS_DISC, '1, '0, '1));
        send_cmd(cmd_of(FN_HEARTBEAT, 5'd1));
        send_cmd(cmd_of(FN_REPORT, 5'd1, NS_DISC, '0, '0, '1));
        send_cmd(cmd_of(FN_HEARTBEAT, 5'd15));
        send_cmd(cmd_of(FN_REPORT, 5'd15, '1, '0, '1, '0));
        send_cmd(cmd_of(FN_SET_STATE, SECONDARY_ID, NS_ACTIVE));
        send_cmd(cmd_of(FN_REPORT, MASTER_ID, NS_DISC, '1, '1, '1));
        send_cmd(cmd_of(FN_SET_STATE, 5'd3, NS_BAD));
        send_cmd(cmd_of(FN_CHECK, '0));
        send_cmd(cmd_of(FN_TICK, '0));
        send_cmd(cmd_of(FN_TICK, '0));
        send_cmd(cmd_of(FN_CHECK, '1));
        send_cmd(cmd_of(FN_HEARTBEAT, 5'd15));
    endtask

    // Master loss seen from a secondary, then worker and unknown roles
    task automatic test_roles();
        drain_events();
        program_monitor(31'd1, 10'd0, 10'd1023, 5'd16, ROLE_SECONDARY);
        send_cmd(cmd_of(FN_SET_STATE, MASTER_ID, NS_ACTIVE));
        send_cmd(cmd_of(FN_TICK, '0));
        send_cmd(cmd_of(FN_CHECK, '0));
        drain_events();
        program_monitor('1, 10'd1023, 10'd1023, 5'd16, ROLE_WORKER);
        send_cmd(cmd_of(FN_CHECK, '0));
        drain_events();
        program_monitor('1, 10'd1023, 10'd1023, 5'd0, ROLE_UNKNOWN);
        send_cmd(cmd_of(FN_CHECK, '0));
    endtask

    // Hold ready low for a long stretch while commands keep coming
    task automatic test_backpressure();
        drain_events();
        idle_on = 1'b0;
        program_monitor(31'd3, 10'd100, 10'd100, 5'd8, ROLE_MASTER);
        ready_holdoff = 80;
        for (int w = 0; w < 8; w++)
            send_cmd(cmd_of(FN_HEARTBEAT, NODE_W'(w)));
        send_cmd(cmd_of(FN_CHECK, '0));
        send_cmd(cmd_of(FN_TICK, '0));
        send_cmd(cmd_of(FN_TICK, '0));
        send_cmd(cmd_of(FN_CHECK, '0));
        drain_events();
        idle_on = 1'b1;
    endtask

    // Random phases, each with its own register setting
    task automatic test_random();
        logic [30:0]      timeout;
        logic [CPU_W-1:0] cpu_th;
        logic [CPU_W-1:0] mem_th;
        logic [WC_W-1:0]  workers;
        for (int phase = 0; phase < 5; phase++)
        begin
            drain_events();
            idle_on = (phase != 2);
            if ($urandom_range(0, 3) == 0)
                timeout = 31'($urandom_range(1, 32'h7FFF_FFFF));
            else
                timeout = 31'($urandom_range(1, 6));
            case ($urandom_range(0, 2))
                0:       cpu_th = '0;
                1:       cpu_th = '1;
                default: cpu_th = CPU_W'($urandom);
            endcase
            case ($urandom_range(0, 2))
                0:       mem_th = '0;
                1:       mem_th = '1;
                default: mem_th = CPU_W'($urandom);
            endcase
            if ($urandom_range(0, 3) == 0)
                workers = WC_W'($urandom_range(0, 31));
            else
                workers = WC_W'($urandom_range(2, 8));
            program_monitor(timeout, cpu_th, mem_th, workers, 2'($urandom_range(0, 3)));
            for (int n = 0; n < 37; n++)
                send_cmd(random_cmd());
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_wdata       = '0;
        cmd_bus.valid   = 1'b0;
        cmd_bus.payload = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_defaults();
        test_fault_events();
        test_roles();
        test_backpressure();
        test_random();

        // Let the last events land, then allow for a stray late beat
        drain_events();
        repeat (40) @(posedge clk);
        if (mismatch_count == 0 && pending_events.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+rtl/core
rtl/core/hbm_pkg.sv
rtl/core/hbm_cmd_if.sv
rtl/core/hbm_evt_if.sv
rtl/core/hbm_node_mem.sv
rtl/core/heartbeat_node_health_monitor.sv
verif/tb.sv
